FILE: rtl/cobd_pkg.sv
package cobd_pkg;

   localparam int NUM_WORDS         = 6;
   localparam int WORD_W            = 16;
   localparam int BYTE_W            = 8;
   localparam int KIND_W            = 2;
   localparam int INDEX_W           = 5;
   localparam int SUM_W             = 19;
   localparam int WORD_BYTES        = 12;
   localparam int PAYLOAD_BYTES_DEF = 28;

   localparam logic [KIND_W-1:0] KIND_SYNC_BAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SUM_BAD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GOOD     = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]                   kind;
      logic [NUM_WORDS-1:0][WORD_W-1:0]    words;
      logic [WORD_W-1:0]                   good;
   } result_type;

endpackage

FILE: rtl/camera_object_block_deframer.sv
// A result enters the result queue as its last byte is taken, with the frame state update.
// Throughput: one link byte per cycle while req_stall is low.
// A two-entry result queue lets bytes flow while one result waits; req_stall rises only
// when both entries are full.
// Reset (synchronous, active high) returns to the first sync byte, clears the good-frame
// count and empties the result queue.
module camera_object_block_deframer #(
   parameter int PAYLOAD_BYTES = cobd_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [cobd_pkg::BYTE_W-1:0]  req_link_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [cobd_pkg::KIND_W-1:0]  rsp_result_kind,
   output logic [cobd_pkg::WORD_W-1:0]  rsp_checksum_word,
   output logic [cobd_pkg::WORD_W-1:0]  rsp_signature_word,
   output logic [cobd_pkg::WORD_W-1:0]  rsp_x_word,
   output logic [cobd_pkg::WORD_W-1:0]  rsp_y_word,
   output logic [cobd_pkg::WORD_W-1:0]  rsp_width_word,
   output logic [cobd_pkg::WORD_W-1:0]  rsp_height_word,
   output logic [cobd_pkg::WORD_W-1:0]  rsp_good_frames
);
   import cobd_pkg::*;

   logic        take;
   logic        res_valid;
   result_type  res;
   result_type  head;
   logic        full;

   assign req_stall = full;
   assign take      = req_valid && !full;

   cobd_core #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .link_byte (req_link_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   cobd_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .pop_stall  (rsp_stall),
      .head_valid (rsp_valid),
      .head_data  (head),
      .full       (full)
   );

   assign rsp_result_kind    = head.kind;
   assign rsp_checksum_word  = head.words[0];
   assign rsp_signature_word = head.words[1];
   assign rsp_x_word         = head.words[2];
   assign rsp_y_word         = head.words[3];
   assign rsp_width_word     = head.words[4];
   assign rsp_height_word    = head.words[5];
   assign rsp_good_frames    = head.good;

   a_full_has_head: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("result queue full without a result at its head");

   a_count_only_good: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind != KIND_GOOD)) |-> (rsp_good_frames == '0))
      else $error("failed frame reports a nonzero good-frame count");

   a_sync_bad_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KIND_SYNC_BAD)) |->
         ((rsp_checksum_word == '0) && (rsp_signature_word == '0) && (rsp_x_word == '0)
          && (rsp_y_word == '0) && (rsp_width_word == '0) && (rsp_height_word == '0)))
      else $error("sync failure carries frame words");

   a_good_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KIND_GOOD)) |-> (rsp_good_frames != '0))
      else $error("good frame reports a zero count");

endmodule

FILE: rtl/cobd_core.sv
module cobd_core #(
   parameter int PAYLOAD_BYTES = cobd_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic [cobd_pkg::BYTE_W-1:0]  link_byte,
   output logic                         res_valid,
   output cobd_pkg::result_type         res
);
   import cobd_pkg::*;

   localparam logic [2:0] PH_SYNC0   = 3'd0;
   localparam logic [2:0] PH_SYNC1   = 3'd1;
   localparam logic [2:0] PH_SYNC2   = 3'd2;
   localparam logic [2:0] PH_SYNC3   = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   localparam logic [BYTE_W-1:0] SYNC_PATTERN [4] = '{8'd85, 8'd170, 8'd85, 8'd170};

   logic [2:0]              phase_ff, phase_in;
   logic [INDEX_W-1:0]      index_ff, index_in;
   logic [BYTE_W-1:0]       hold_ff, hold_in;
   logic [WORD_W-1:0]       words_ff [NUM_WORDS];
   logic [WORD_W-1:0]       words_in [NUM_WORDS];
   logic [WORD_W-1:0]       count_ff, count_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;

   logic [INDEX_W-1:0]      index_next;
   logic                    word_wr;
   logic [2:0]              slot;
   logic [WORD_W-1:0]       new_word;
   logic [SUM_W-1:0]        sum_base;
   logic                    frame_done;
   logic                    sum_ok;

   assign index_next = index_ff + INDEX_W'(1);
   assign word_wr    = (index_ff < INDEX_W'(WORD_BYTES)) && index_ff[0];
   assign slot       = index_ff[3:1];
   assign new_word   = {link_byte, hold_ff};
   assign sum_base   = (index_ff == '0) ? '0 : sum_ff;
   assign frame_done = (index_next >= INDEX_W'(PAYLOAD_BYTES)) || (index_next == '0);
   assign sum_ok     = (sum_in == {{(SUM_W-WORD_W){1'b0}}, words_in[0]});

   always_comb begin
      phase_in  = phase_ff;
      index_in  = index_ff;
      hold_in   = hold_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      res_valid = 1'b0;
      res       = '0;
      for (int j = 0; j < NUM_WORDS; j++) begin
         words_in[j] = words_ff[j];
      end
      if (take) begin
         unique case (phase_ff) inside
            PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_SYNC3: begin
               if (link_byte == SYNC_PATTERN[phase_ff[1:0]]) begin
                  phase_in = phase_ff + 3'd1;
                  index_in = '0;
               end else begin
                  // drop the attempt and report it with blank words
                  phase_in  = PH_SYNC0;
                  count_in  = '0;
                  res_valid = 1'b1;
                  res.kind  = KIND_SYNC_BAD;
               end
            end
            PH_PAYLOAD: begin
               if ((index_ff < INDEX_W'(WORD_BYTES)) && !index_ff[0]) begin
                  hold_in = link_byte;
               end
               for (int j = 0; j < NUM_WORDS; j++) begin
                  if (word_wr && (slot == 3'(j))) begin
                     words_in[j] = new_word;
                  end
               end
               // keep a running sum of words one to five
               sum_in   = sum_base + ((word_wr && (slot != 3'd0)) ?
                          {{(SUM_W-WORD_W){1'b0}}, new_word} : '0);
               index_in = index_next;
               if (frame_done) begin
                  phase_in  = PH_SYNC0;
                  index_in  = '0;
                  res_valid = 1'b1;
                  for (int j = 0; j < NUM_WORDS; j++) begin
                     res.words[j] = words_in[j];
                  end
                  if (sum_ok) begin
                     count_in = (count_ff == '1) ? count_ff : count_ff + WORD_W'(1);
                     res.kind = KIND_GOOD;
                     res.good = count_in;
                  end else begin
                     count_in = '0;
                     res.kind = KIND_SUM_BAD;
                  end
               end
            end
            default: begin
               phase_in = PH_SYNC0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC0;
         index_ff <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      sum_ff  <= sum_in;
      for (int j = 0; j < NUM_WORDS; j++) begin
         words_ff[j] <= words_in[j];
      end
   end

endmodule

FILE: rtl/cobd_outq.sv
module cobd_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cobd_pkg::result_type  push_data,
   input  logic                  pop_stall,
   output logic                  head_valid,
   output cobd_pkg::result_type  head_data,
   output logic                  full
);
   import cobd_pkg::*;

   logic        head_valid_ff, head_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   result_type  head_ff, head_in;
   result_type  skid_ff, skid_in;
   logic        pop;

   assign pop        = head_valid_ff && !pop_stall;
   assign head_valid = head_valid_ff;
   assign head_data  = head_ff;
   assign full       = skid_valid_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            head_valid_in = push;
            head_in       = push_data;
         end
      end else if (!head_valid_ff) begin
         head_valid_in = push;
         head_in       = push_data;
      end else if (push) begin
         // head is held by the receiver: park the transaction in the skid slot
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule
